### src/tbl_pkg.sv
package tbl_pkg;

  // Fixed field widths
  localparam int TIME_W = 64;
  localparam int NS_W   = 30;
  localparam int ITER_W = 7;
  localparam int ADDR_W = 4;
  localparam int APB_W  = 64;
  localparam int STAT_W = 2;

  localparam logic [TIME_W-1:0] NS_PER_SEC = 64'd1_000_000_000;

  typedef enum logic [STAT_W-1:0] {
    STAT_GRANT   = 2'd0,
    STAT_DENY    = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

  // Start request for the serial divider
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

endpackage

### src/tbl_mul.sv
module tbl_mul #(
  parameter int BW = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tbl_pkg::TIME_W-1:0]   a_i,
  input  logic [BW-1:0]                b_i,
  output logic                         done_o,
  output logic [tbl_pkg::TIME_W+BW-1:0] prod_o
);

  localparam int AW = tbl_pkg::TIME_W;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [AW-1:0] hi_q, hi_d;
  logic [BW-1:0] lo_q, lo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [AW:0]   sum;

  // Add the multiplicand on a set multiplier bit, then shift right one bit
  always_comb begin
    sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d = sum[AW:1];
    lo_d = {sum[0], lo_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### src/tbl_div.sv
module tbl_div #(
  parameter int DW = 104,
  parameter int VW = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tbl_pkg::div_ctl_t          ctl_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [VW-1:0]              divisor_i,
  output logic                       done_o,
  output logic [tbl_pkg::TIME_W-1:0] quot_o,
  output logic                       over_o
);

  localparam int QW = tbl_pkg::TIME_W;
  localparam int IW = tbl_pkg::ITER_W;

  logic [DW-1:0] num_q;
  logic [VW-1:0] den_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [QW-1:0] quot_q;
  logic [IW-1:0] cnt_q;
  logic          busy_q, done_q, over_q;
  logic [VW:0]   trial, diff;
  logic          qbit;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, num_q[DW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? diff[VW-1:0] : trial[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
      over_q <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[DW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[QW-2:0], qbit};
      // a set bit above the 64-bit quotient saturates the result
      if (qbit && (cnt_q > IW'(QW))) begin
        over_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign over_o = over_q;

endmodule

### src/token_bucket_limiter.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: now_time, cost
// m_axis    out  tvalid/tready           tdata: retry_wait, tokens_left; tuser: status
// apb       in   psel/penable, pready=1  refill_rate at 0x0, burst_size at 0x8
//
// One request at a time. An invalid cost goes straight to the result; a first
// request is judged on a full bucket, with no refill. A later request runs the
// shift-add multiplier and, unless its product overflows, the divide by 1e9. A
// denial at a nonzero rate adds the deficit multiply and the divide by the rate.
// Reset is asynchronous, active low, and fills the bucket to the reset burst. A
// stalled result holds in the output register; the next request waits at its end.
module token_bucket_limiter #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // s_axis_tdata: now_time [63:0], cost [TOK_W+63:64], zero fill above
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((64+INT_BITS+FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,
  // m_axis_tdata: retry_wait [63:0], tokens_left [TOK_W+63:64], zero fill above
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((64+INT_BITS+FRAC_BITS+7)/8)*8-1:0] m_axis_tdata,
  // m_axis_tuser: status [1:0]
  output logic [tbl_pkg::STAT_W-1:0]          m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tbl_pkg::ADDR_W-1:0]          paddr,
  input  logic [tbl_pkg::APB_W-1:0]           pwdata,
  output logic [tbl_pkg::APB_W-1:0]           prdata,
  output logic                                pready
);

  localparam int TW    = tbl_pkg::TIME_W;
  localparam int NW    = tbl_pkg::NS_W;
  localparam int TOK_W = INT_BITS + FRAC_BITS;
  localparam int VW    = (TOK_W > NW) ? TOK_W : NW;
  localparam int DW    = TW + TOK_W;
  localparam int PAD_W = DW - TOK_W - NW;
  localparam int BUS_W = ((TW + TOK_W + 7) / 8) * 8;

  localparam logic [TOK_W-1:0] RESET_ONE = TOK_W'(1) << FRAC_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_JUDGE = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_DIV2  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [TOK_W-1:0] rate_q, burst_q;
  logic [TOK_W-1:0] token_q, token_d;
  logic [TW-1:0]    last_q, last_d;
  logic             started_q, started_d;
  logic [TW-1:0]    now_q;
  logic [TOK_W-1:0] cost_q;

  tbl_pkg::status_e res_status_q, res_status_d;
  logic [TW-1:0]    res_wait_q, res_wait_d;

  logic             out_valid_q;
  tbl_pkg::status_e out_status_q;
  logic [TW-1:0]    out_wait_q;
  logic [TOK_W-1:0] out_tok_q;

  logic             in_acc, out_free, cfg_we;
  logic             cost_bad, enough;
  logic [TOK_W-1:0] deficit;
  logic [TW:0]      refill_sum;

  logic             mul_start, mul_done;
  logic [TW-1:0]    mul_a;
  logic [TOK_W-1:0] mul_b;
  logic [DW-1:0]    prod;

  tbl_pkg::div_ctl_t  div_ctl;
  logic [DW-1:0]      div_num;
  logic [VW-1:0]      div_den;
  logic               div_done, div_over;
  logic [TW-1:0]      quot;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration: decode on the 8-byte word, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[3] ? tbl_pkg::APB_W'(burst_q) : tbl_pkg::APB_W'(rate_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RESET_ONE;
      burst_q <= RESET_ONE;
    end else if (cfg_we) begin
      if (paddr[3]) begin
        burst_q <= pwdata[TOK_W-1:0];
      end else begin
        rate_q <= pwdata[TOK_W-1:0];
      end
    end
  end

  // Judge on the latched request
  assign cost_bad   = (cost_q == '0) || (cost_q > burst_q);
  assign enough     = (token_q >= cost_q);
  assign deficit    = cost_q - token_q;
  assign refill_sum = {1'b0, quot} + (TW + 1)'(token_q);

  // Shared multiplier: elapsed * rate for a refill, 1e9 * deficit for a wait
  assign mul_start = ((state_q == S_CHECK) && !cost_bad && started_q) ||
                     ((state_q == S_JUDGE) && !enough && (rate_q != '0));
  assign mul_a     = (state_q == S_CHECK) ? (now_q - last_q) : tbl_pkg::NS_PER_SEC;
  assign mul_b     = (state_q == S_CHECK) ? rate_q : deficit;

  // Divider: low product word / 1e9, or the left-aligned deficit product / rate
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.iters = tbl_pkg::ITER_W'(TW);
    div_num       = {prod[TW-1:0], {TOK_W{1'b0}}};
    div_den       = VW'(tbl_pkg::NS_PER_SEC);
    if (state_q == S_MUL1) begin
      div_ctl.start = mul_done && (prod[DW-1:TW] == '0);
    end else if (state_q == S_MUL2) begin
      div_ctl.start = mul_done;
      div_ctl.iters = tbl_pkg::ITER_W'(TOK_W + NW);
      div_num       = {prod[TOK_W+NW-1:0], {PAD_W{1'b0}}};
      div_den       = VW'(rate_q);
    end
  end

  tbl_mul #(
    .BW(TOK_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  tbl_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (quot),
    .over_o     (div_over)
  );

  always_comb begin
    state_d      = state_q;
    token_d      = token_q;
    last_d       = last_q;
    started_d    = started_q;
    res_status_d = res_status_q;
    res_wait_d   = res_wait_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cost_bad) begin
          // leave the state untouched
          res_status_d = tbl_pkg::STAT_INVALID;
          res_wait_d   = '1;
          state_d      = S_DONE;
        end else if (!started_q) begin
          // first request starts a full bucket, no refill
          started_d = 1'b1;
          last_d    = now_q;
          token_d   = burst_q;
          state_d   = S_JUDGE;
        end else begin
          last_d  = now_q;
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          if (prod[DW-1:TW] != '0) begin
            // product overflow: go straight to a full bucket
            token_d = burst_q;
            state_d = S_JUDGE;
          end else begin
            state_d = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          token_d = (refill_sum > (TW + 1)'(burst_q)) ? burst_q : refill_sum[TOK_W-1:0];
          state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (enough) begin
          token_d      = token_q - cost_q;
          res_status_d = tbl_pkg::STAT_GRANT;
          res_wait_d   = '0;
          state_d      = S_DONE;
        end else if (rate_q == '0) begin
          res_status_d = tbl_pkg::STAT_DENY;
          res_wait_d   = '1;
          state_d      = S_DONE;
        end else begin
          res_status_d = tbl_pkg::STAT_DENY;
          state_d      = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          // saturate, otherwise round up past the last whole nanosecond
          res_wait_d = (div_over || (&quot)) ? '1 : quot + 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      token_q     <= RESET_ONE;
      last_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      token_q   <= token_d;
      last_q    <= last_d;
      started_q <= started_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request latch, pending result, output beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q  <= s_axis_tdata[TW-1:0];
      cost_q <= s_axis_tdata[TW+TOK_W-1:TW];
    end
    res_status_q <= res_status_d;
    res_wait_q   <= res_wait_d;
    if ((state_q == S_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_wait_q   <= res_wait_q;
      out_tok_q    <= token_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = BUS_W'({out_tok_q, out_wait_q});
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  a_grant_no_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tbl_pkg::STAT_GRANT)) |-> (out_wait_q == '0))
    else $error("granted beat with nonzero wait");

  a_invalid_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tbl_pkg::STAT_INVALID)) |-> (&out_wait_q))
    else $error("invalid beat without saturated wait");

  a_mul_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> ((state_q == S_MUL1) || (state_q == S_MUL2)))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == S_DIV1) || (state_q == S_DIV2)))
    else $error("divider finished outside a divide step");
`endif

endmodule
